>>> rtl/sdspi_pkg.sv
// package for the sd card spi host sequencer
// phases, stages, status and action codes; no dependencies
package sdspi_pkg;

  localparam int SectorBytes = 512;
  localparam int CsdBytes    = 16;
  localparam int WakeBytes   = 10;

  typedef enum logic [2:0] {
    ACT_BYTE = 3'd0, ACT_INIT = 3'd1, ACT_READ = 3'd2, ACT_WRITE = 3'd3, ACT_CAP = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BUSY = 3'd1, ST_REJECT = 3'd2, ST_TOKEN = 3'd3,
    ST_CMD = 3'd4, ST_NOCARD = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CARD_NONE = 3'd0, CARD_MMC = 3'd1, CARD_SD1 = 3'd2, CARD_SD2 = 3'd3, CARD_SDHC = 3'd4
  } card_t;

  typedef enum logic [4:0] {
    P_IDLE, P_WAKE, P_CDESEL, P_CGAP, P_CREADY, P_CFRAME, P_CSTUFF, P_CRESP,
    P_TRAIL, P_TOKEN, P_DATA, P_DCRC, P_WREADY, P_WDATA, P_WCRC, P_WRESP, P_WSTOP
  } phase_t;

  typedef enum logic [4:0] {
    S_NONE, S_CMD0, S_CMD8, S_CMD8_TRAIL, S_V2_55, S_V2_41, S_CMD58, S_OCR,
    S_V1_55, S_V1_41, S_LOOP_55, S_LOOP_41, S_CMD1, S_CMD16, S_RD_ONE,
    S_RD_ONE_DATA, S_RD_MULTI_CMD, S_RD_MULTI_DATA, S_RD_STOP, S_WR_55, S_WR_23,
    S_WR_ONE_CMD, S_WR_ONE, S_WR_MULTI_CMD, S_WR_MULTI, S_WR_STOP, S_CSD_CMD,
    S_CSD_DATA
  } stage_t;

  localparam logic [2:0] CFG_RESET_RETRIES = 3'd0;
  localparam logic [2:0] CFG_IDLE_RETRIES  = 3'd1;
  localparam logic [2:0] CFG_RESP_POLLS    = 3'd2;
  localparam logic [2:0] CFG_TOKEN_POLLS   = 3'd3;
  localparam logic [2:0] CFG_READY_POLLS   = 3'd4;

  localparam logic [7:0] TOKEN_START  = 8'hFE;
  localparam logic [7:0] TOKEN_MULTI  = 8'hFC;
  localparam logic [7:0] TOKEN_STOP   = 8'hFD;
  localparam logic [7:0] DATA_ACCEPT  = 8'h05;
  localparam logic [7:0] IDLE_BYTE    = 8'hFF;

  // capacity in sectors from a 16-byte csd
  function automatic logic [31:0] csd_sectors(input logic [7:0] c [16]);
    logic [21:0] cs2;
    logic [4:0]  n;
    logic [12:0] cs1;
    logic [31:0] w;
    begin
      cs2 = {c[7][5:0], c[8], c[9]};
      n = 5'({1'b0, c[5][3:0]}) + 5'(c[10][7]) + 5'({c[9][1:0], 1'b0}) + 5'd2;
      cs1 = 13'({c[6][1:0], c[7], c[8][7:6]}) + 13'd1;
      w = 32'(cs1);
      if (c[0][7:6] == 2'b01) begin
        if (cs2 == 22'h3FFFFF) csd_sectors = 32'hFFFFFFFF;
        else csd_sectors = {(22'(cs2) + 22'd1), 10'd0};
      end else if (n >= 5'd9) begin
        csd_sectors = w << (n - 5'd9);
      end else begin
        csd_sectors = w >> (5'd9 - n);
      end
    end
  endfunction

endpackage

>>> rtl/sd_spi_host_sequencer_top.sv
// sd card spi-mode host sequencer, top level
// depends on sdspi_pkg
// One item is one spi byte transfer: an action starts init, sector read, sector write or a csd
// capacity query, or (action 0) hands back the miso byte of the transfer the previous result
// asked for. Every accepted item yields exactly one registered result naming the next
// mosi byte and chip-select level. A new item is taken every cycle while the result register
// is empty or being drained; the sequencer state is a registered fsm with one pass of logic.
// Starting an action while another runs drops the running one. No clearing pass after reset.
module sd_spi_host_sequencer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [7:0]  miso_byte,
  input  logic [31:0] sector,
  input  logic [7:0]  block_count,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  mosi_byte,
  output logic        chip_select,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        wants_write_data,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [7:0]  last_response,
  output logic [2:0]  card_kind,
  output logic [31:0] sector_total,
  output logic        fast_clock,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import sdspi_pkg::*;

  logic [7:0]  reset_retries;
  logic [15:0] idle_exit_retries;
  logic [7:0]  response_polls;
  logic [15:0] token_polls;
  logic [23:0] ready_polls;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [23:0] poll_counter, poll_counter_next;
  logic [9:0]  byte_index, byte_index_next;
  logic [47:0] command_frame, command_frame_next;
  logic [2:0]  card_type_reg, card_type_next;
  logic [7:0]  blocks_left, blocks_left_next;
  logic [31:0] card_address, card_address_next;
  logic [7:0]  response_reg, response_next;
  logic [15:0] loop_count, loop_count_next;
  logic [2:0]  op_status, op_status_next;
  logic        sub_result, sub_result_next;
  logic [1:0]  sub_code, sub_code_next;  // write result code: ready timeout or data response result
  logic [31:0] total, total_next;
  logic        fast_flag, fast_next;
  logic [7:0]  reply_bytes [16];
  logic        reply_we;
  logic [3:0]  reply_addr;

  logic [7:0]  o_mosi;
  logic        o_cs, o_rvalid, o_wants, o_done;
  logic [7:0]  o_rdata;
  logic [2:0]  o_status;

  logic take;
  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_retries <= 8'd200;
      idle_exit_retries <= 16'd65534;
      response_polls <= 8'd20;
      token_polls <= 16'hFFFF;
      ready_polls <= 24'hFFFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESET_RETRIES: reset_retries <= cfg_data[7:0];
        CFG_IDLE_RETRIES:  idle_exit_retries <= cfg_data[15:0];
        CFG_RESP_POLLS:    response_polls <= cfg_data[7:0];
        CFG_TOKEN_POLLS:   token_polls <= cfg_data[15:0];
        CFG_READY_POLLS:   ready_polls <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole sequencer step, one combinational pass
  always_comb begin
    logic [7:0]  rx;
    logic [23:0] pc1;
    logic        do_proceed;
    logic        cmd_go;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    stage_t      cmd_stage;
    logic        fin;
    logic [2:0]  fin_st;
    logic        fin_init;
    logic [2:0]  fin_code;
    logic [2:0]  k;
    rx = miso_byte;
    pc1 = poll_counter + 24'd1;
    do_proceed = 1'b0;
    cmd_go = 1'b0; cmd = '0; arg = '0; crc = 8'h01; cmd_stage = S_NONE;
    fin = 1'b0; fin_st = ST_OK; fin_init = 1'b0; fin_code = ST_OK;
    k = 3'd0;
    phase_next = phase; stage_next = stage; poll_counter_next = poll_counter;
    byte_index_next = byte_index; command_frame_next = command_frame;
    card_type_next = card_type_reg; blocks_left_next = blocks_left;
    card_address_next = card_address; response_next = response_reg;
    loop_count_next = loop_count; op_status_next = op_status;
    sub_result_next = sub_result; sub_code_next = sub_code;
    total_next = total; fast_next = fast_flag;
    reply_we = 1'b0; reply_addr = byte_index[3:0];
    o_mosi = IDLE_BYTE; o_cs = 1'b1; o_rdata = '0; o_rvalid = 1'b0;
    o_wants = 1'b0; o_done = 1'b0; o_status = ST_OK;

    if (action >= ACT_INIT && action <= ACT_CAP) begin
      op_status_next = ST_OK;
      sub_result_next = 1'b0;
      sub_code_next = 2'd0;
      if (action == ACT_INIT) begin
        fast_next = 1'b0; card_type_next = CARD_NONE; phase_next = P_WAKE;
        stage_next = S_NONE; byte_index_next = '0;
      end else if (action == ACT_CAP) begin
        cmd_go = 1'b1; cmd = 6'd9; cmd_stage = S_CSD_CMD;
      end else if (block_count == 8'd0) begin
        fin = 1'b1;
      end else begin
        card_address_next = (card_type_reg == CARD_SDHC) ? sector : {sector[22:0], 9'd0};
        blocks_left_next = block_count;
        cmd_go = 1'b1; arg = card_address_next;
        if (action == ACT_READ) begin
          cmd = (block_count == 8'd1) ? 6'd17 : 6'd18;
          cmd_stage = (block_count == 8'd1) ? S_RD_ONE : S_RD_MULTI_CMD;
        end else if (block_count == 8'd1) begin
          cmd = 6'd24; cmd_stage = S_WR_ONE_CMD;
        end else if (card_type_reg != CARD_MMC) begin
          cmd = 6'd55; arg = '0; cmd_stage = S_WR_55;
        end else begin
          cmd = 6'd25; cmd_stage = S_WR_MULTI_CMD;
        end
      end
    end else if (phase != P_IDLE) begin
      unique case (phase)
        P_WAKE: begin
          byte_index_next = byte_index + 10'd1;
          if (byte_index_next >= 10'(WakeBytes)) begin
            loop_count_next = 16'(reset_retries);
            cmd_go = 1'b1; cmd = 6'd0; crc = 8'h95; cmd_stage = S_CMD0;
          end
        end
        P_CDESEL: phase_next = P_CGAP;
        P_CGAP: begin phase_next = P_CREADY; poll_counter_next = '0; o_cs = 1'b0; end
        P_CREADY: begin
          o_cs = 1'b0;
          if (rx == 8'hFF) begin
            phase_next = P_CFRAME; byte_index_next = '0;
          end else begin
            poll_counter_next = pc1;
            if (pc1 >= ready_polls) begin response_next = 8'hFF; do_proceed = 1'b1; end
          end
        end
        P_CFRAME: begin
          o_cs = 1'b0;
          byte_index_next = byte_index + 10'd1;
          if (byte_index_next < 10'd8) begin
            k = byte_index_next[2:0];
            if (k != 3'd0 && k != 3'd7) o_mosi = command_frame[8*(6-k) +: 8];
          end else begin
            phase_next = (command_frame[45:40] == 6'd12) ? P_CSTUFF : P_CRESP;
            poll_counter_next = '0;
          end
        end
        P_CSTUFF: begin phase_next = P_CRESP; poll_counter_next = '0; o_cs = 1'b0; end
        P_CRESP: begin
          o_cs = 1'b0;
          poll_counter_next = pc1;
          if (rx != 8'hFF || pc1 > 24'(response_polls)) begin
            response_next = rx; do_proceed = 1'b1;
          end
        end
        P_TRAIL: begin
          o_cs = 1'b0;
          reply_we = 1'b1;
          byte_index_next = byte_index + 10'd1;
          if (byte_index_next >= 10'd4) do_proceed = 1'b1;
        end
        P_TOKEN: begin
          o_cs = 1'b0;
          if (rx == TOKEN_START) begin
            phase_next = P_DATA; byte_index_next = '0;
          end else begin
            poll_counter_next = pc1;
            if (pc1 >= 24'(token_polls)) begin sub_result_next = 1'b1; do_proceed = 1'b1; end
          end
        end
        P_DATA: begin
          o_cs = 1'b0;
          if (stage == S_CSD_DATA) reply_we = 1'b1;
          else begin o_rdata = rx; o_rvalid = 1'b1; end
          byte_index_next = byte_index + 10'd1;
          if ((stage == S_CSD_DATA && byte_index_next >= 10'(CsdBytes)) ||
              (stage != S_CSD_DATA && byte_index == 10'(SectorBytes - 1))) begin
            phase_next = P_DCRC; byte_index_next = '0;
          end
        end
        P_DCRC: begin
          o_cs = 1'b0;
          byte_index_next = byte_index + 10'd1;
          if (byte_index_next >= 10'd2) begin sub_result_next = 1'b0; do_proceed = 1'b1; end
        end
        P_WREADY: begin
          o_cs = 1'b0;
          if (rx == 8'hFF) begin
            if (stage == S_WR_STOP) begin phase_next = P_WSTOP; o_mosi = TOKEN_STOP; end
            else begin
              phase_next = P_WDATA; byte_index_next = '0;
              o_mosi = (stage == S_WR_ONE) ? TOKEN_START : TOKEN_MULTI;
              o_wants = 1'b1;
            end
          end else begin
            poll_counter_next = pc1;
            if (pc1 >= ready_polls) begin
              sub_result_next = 1'b1; sub_code_next = 2'd1; do_proceed = 1'b1;
            end
          end
        end
        P_WDATA: begin
          o_cs = 1'b0; o_mosi = write_data;
          byte_index_next = byte_index + 10'd1;
          if (byte_index == 10'(SectorBytes - 1)) begin
            phase_next = P_WCRC; byte_index_next = '0;
          end else o_wants = 1'b1;
        end
        P_WCRC: begin
          o_cs = 1'b0;
          byte_index_next = byte_index + 10'd1;
          if (byte_index_next >= 10'd3) phase_next = P_WRESP;
        end
        P_WRESP: begin
          sub_code_next = ((rx & 8'h1F) == DATA_ACCEPT) ? 2'd0 : 2'd2;
          sub_result_next = ((rx & 8'h1F) != DATA_ACCEPT);
          do_proceed = 1'b1;
        end
        P_WSTOP: begin
          sub_result_next = 1'b0; sub_code_next = 2'd0; do_proceed = 1'b1;
        end
        default: phase_next = P_IDLE;
      endcase
    end

    if (do_proceed) begin
      unique case (stage)
        S_CMD0: begin
          if (response_next == 8'd1) begin
            cmd_go = 1'b1; cmd = 6'd8; arg = 32'h1AA; crc = 8'h87; cmd_stage = S_CMD8;
          end else if (loop_count == 16'd0) begin
            fin_init = 1'b1; fin_code = ST_NOCARD;
          end else begin
            loop_count_next = loop_count - 16'd1;
            cmd_go = 1'b1; cmd = 6'd0; crc = 8'h95; cmd_stage = S_CMD0;
          end
        end
        S_CMD8: begin
          if (response_next == 8'd1) begin
            stage_next = S_CMD8_TRAIL; phase_next = P_TRAIL; byte_index_next = '0; o_cs = 1'b0;
          end else begin cmd_go = 1'b1; cmd = 6'd55; cmd_stage = S_V1_55; end
        end
        S_CMD8_TRAIL: begin
          if (reply_bytes[2] == 8'h01 && rx == 8'hAA) begin
            loop_count_next = idle_exit_retries;
            cmd_go = 1'b1; cmd = 6'd55; cmd_stage = S_V2_55;
          end else begin fin_init = 1'b1; fin_code = ST_CMD; end
        end
        S_V2_55: begin cmd_go = 1'b1; cmd = 6'd41; arg = 32'h40000000; cmd_stage = S_V2_41; end
        S_V2_41, S_LOOP_41, S_CMD1: begin
          if (response_next == 8'd0) begin
            cmd_go = 1'b1;
            if (stage == S_V2_41) begin cmd = 6'd58; cmd_stage = S_CMD58; end
            else begin cmd = 6'd16; arg = 32'(SectorBytes); cmd_stage = S_CMD16; end
          end else if (loop_count == 16'd0) begin
            card_type_next = CARD_NONE; fin_init = 1'b1; fin_code = ST_CMD;
          end else begin
            loop_count_next = loop_count - 16'd1;
            cmd_go = 1'b1;
            if (stage == S_CMD1) begin cmd = 6'd1; cmd_stage = S_CMD1; end
            else begin
              cmd = 6'd55;
              cmd_stage = (stage == S_V2_41) ? S_V2_55 : S_LOOP_55;
            end
          end
        end
        S_CMD58: begin
          if (response_next == 8'd0) begin
            stage_next = S_OCR; phase_next = P_TRAIL; byte_index_next = '0; o_cs = 1'b0;
          end else begin fin_init = 1'b1; fin_code = ST_CMD; end
        end
        S_OCR: begin
          // first ocr byte holds ccs
          card_type_next = reply_bytes[0][6] ? CARD_SDHC : CARD_SD2;
          fin_init = 1'b1; fin_code = ST_CMD;
        end
        S_V1_55: begin cmd_go = 1'b1; cmd = 6'd41; cmd_stage = S_V1_41; end
        S_V1_41: begin
          loop_count_next = idle_exit_retries;
          cmd_go = 1'b1;
          if (response_next <= 8'd1) begin
            card_type_next = CARD_SD1; cmd = 6'd55; cmd_stage = S_LOOP_55;
          end else begin
            card_type_next = CARD_MMC; cmd = 6'd1; cmd_stage = S_CMD1;
          end
        end
        S_LOOP_55: begin cmd_go = 1'b1; cmd = 6'd41; cmd_stage = S_LOOP_41; end
        S_CMD16: begin
          if (response_next != 8'd0) card_type_next = CARD_NONE;
          fin_init = 1'b1; fin_code = ST_CMD;
        end
        S_RD_ONE, S_CSD_CMD: begin
          if (response_next == 8'd0) begin
            stage_next = (stage == S_RD_ONE) ? S_RD_ONE_DATA : S_CSD_DATA;
            phase_next = P_TOKEN; poll_counter_next = '0; o_cs = 1'b0;
          end else begin
            if (stage == S_CSD_CMD) total_next = '0;
            fin = 1'b1; fin_st = ST_CMD;
          end
        end
        S_RD_ONE_DATA: begin fin = 1'b1; fin_st = sub_result_next ? ST_TOKEN : ST_OK; end
        S_RD_MULTI_CMD: begin
          stage_next = S_RD_MULTI_DATA; phase_next = P_TOKEN;
          poll_counter_next = '0; o_cs = 1'b0;
        end
        S_RD_MULTI_DATA: begin
          blocks_left_next = blocks_left - 8'd1;
          if (!sub_result_next && blocks_left_next != 8'd0) begin
            phase_next = P_TOKEN; poll_counter_next = '0; o_cs = 1'b0;
          end else begin
            op_status_next = sub_result_next ? ST_TOKEN : ST_OK;
            cmd_go = 1'b1; cmd = 6'd12; cmd_stage = S_RD_STOP;
          end
        end
        S_RD_STOP: begin fin = 1'b1; fin_st = op_status; end
        S_WR_55: begin cmd_go = 1'b1; cmd = 6'd23; arg = 32'(blocks_left); cmd_stage = S_WR_23; end
        S_WR_23: begin cmd_go = 1'b1; cmd = 6'd25; arg = card_address; cmd_stage = S_WR_MULTI_CMD; end
        S_WR_ONE_CMD, S_WR_MULTI_CMD: begin
          if (response_next == 8'd0) begin
            stage_next = (stage == S_WR_ONE_CMD) ? S_WR_ONE : S_WR_MULTI;
            phase_next = P_WREADY; poll_counter_next = '0; o_cs = 1'b0;
          end else begin fin = 1'b1; fin_st = ST_CMD; end
        end
        S_WR_ONE: begin fin = 1'b1; fin_st = 3'(sub_code_next); end
        S_WR_MULTI: begin
          blocks_left_next = blocks_left - 8'd1;
          phase_next = P_WREADY; poll_counter_next = '0; o_cs = 1'b0;
          if (sub_result_next || blocks_left_next == 8'd0) begin
            op_status_next = 3'(sub_code_next); stage_next = S_WR_STOP;
          end
        end
        S_WR_STOP: begin
          fin = 1'b1; fin_st = (op_status != ST_OK) ? op_status : 3'(sub_code_next);
        end
        S_CSD_DATA: begin
          fin = 1'b1;
          if (sub_result_next) begin total_next = '0; fin_st = ST_TOKEN; end
          else begin total_next = csd_sectors(reply_bytes); fin_st = ST_OK; end
        end
        default: fin = 1'b1;
      endcase
    end

    if (fin_init) begin
      fast_next = 1'b1; fin = 1'b1;
      fin_st = (card_type_next != CARD_NONE) ? ST_OK : fin_code;
    end
    if (cmd_go) begin
      command_frame_next = {2'b01, cmd, arg, crc};
      stage_next = cmd_stage; phase_next = P_CDESEL;
      o_mosi = IDLE_BYTE; o_cs = 1'b1;
    end
    if (fin) begin
      o_mosi = IDLE_BYTE; o_cs = 1'b1; o_done = 1'b1; o_status = fin_st;
      phase_next = P_IDLE; stage_next = S_NONE;
    end
  end

  // csd bytes land in the reply store too; the last cmd8 trailing byte is read straight off the bus
  always_ff @(posedge clk) begin
    if (take && reply_we) reply_bytes[reply_addr] <= miso_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; stage <= S_NONE; poll_counter <= '0; byte_index <= '0;
      command_frame <= '0; card_type_reg <= CARD_NONE; blocks_left <= '0;
      card_address <= '0; response_reg <= 8'hFF; loop_count <= '0; op_status <= ST_OK;
      sub_result <= 1'b0; sub_code <= 2'd0; total <= '0; fast_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        phase <= phase_next; stage <= stage_next; poll_counter <= poll_counter_next;
        byte_index <= byte_index_next; command_frame <= command_frame_next;
        card_type_reg <= card_type_next; blocks_left <= blocks_left_next;
        card_address <= card_address_next; response_reg <= response_next;
        loop_count <= loop_count_next; op_status <= op_status_next;
        sub_result <= sub_result_next; sub_code <= sub_code_next;
        total <= total_next; fast_flag <= fast_next;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mosi_byte <= o_mosi; chip_select <= o_cs; read_data <= o_rdata;
      read_valid <= o_rvalid; wants_write_data <= o_wants; done_res <= o_done;
      status <= o_status; last_response <= response_next; card_kind <= card_type_next;
      sector_total <= total_next; fast_clock <= fast_next;
    end
  end

`ifndef SYNTHESIS
  a_done_deselects: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> chip_select) else $error("done without deselect");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    take && o_done |=> phase == P_IDLE) else $error("phase not idle after done");
  a_rvalid_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> !chip_select && !done_res) else $error("read byte unselected");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(mosi_byte) && out_valid) else $error("result lost");
`endif

endmodule
